>>> hdl/i2cbb_pkg.sv
package i2cbb_pkg;

	localparam int unsigned DLY_W = 16;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;
	localparam logic [2:0] PH_END   = 3'd7;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef struct packed {
		cmd_t       kind;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       sda_in;
		logic       scl_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} res_t;

endpackage

>>> hdl/i2cbb_front.sv
module i2cbb_front #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          op,
	input  logic [7:0]          tx_byte,
	input  logic                ack_to_send,
	input  logic                sda_in,
	input  logic                scl_in,
	output logic                q_valid,
	output i2cbb_pkg::item_t    q_item,
	input  logic                q_pop
);

	localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	i2cbb_pkg::item_t  mem_q [DEPTH];
	i2cbb_pkg::item_t  item;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;

	always_comb begin
		item.tx_byte     = tx_byte;
		item.ack_to_send = ack_to_send;
		item.sda_in      = sda_in;
		item.scl_in      = scl_in;
		unique case (op)
			i2cbb_pkg::OP_START: item.kind = i2cbb_pkg::CMD_START;
			i2cbb_pkg::OP_STOP:  item.kind = i2cbb_pkg::CMD_STOP;
			i2cbb_pkg::OP_WRITE: item.kind = i2cbb_pkg::CMD_WRITE;
			i2cbb_pkg::OP_READ:  item.kind = i2cbb_pkg::CMD_READ;
			default:             item.kind = i2cbb_pkg::CMD_IDLE;
		endcase
	end

	assign in_stall = (count_q == CNT_W'(DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/i2cbb_engine.sv
module i2cbb_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  i2cbb_pkg::item_t                  q_item,
	output logic                              q_pop,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [i2cbb_pkg::DLY_W-1:0]       cfg_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output i2cbb_pkg::res_t                   res
);

	i2cbb_pkg::cmd_t              kind_q, n_kind;
	logic [2:0]                   phase_q, n_phase;
	logic [3:0]                   bit_q, n_bit;
	logic [7:0]                   shift_q, n_shift;
	logic [i2cbb_pkg::DLY_W-1:0]  delay_q, n_delay;
	logic [i2cbb_pkg::DLY_W-1:0]  dly_cfg_q;
	logic                         ack_flag_q, n_ack_flag;
	logic                         scl_q, n_scl;
	logic                         sda_q, n_sda;
	logic [7:0]                   rx_q, n_rx;
	logic                         ack_hold_q, n_ack_hold;
	logic                         do_act;
	logic                         fin;
	logic                         done;
	logic                         out_valid_q;
	i2cbb_pkg::res_t              res_q, n_res;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign q_pop     = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		n_kind     = kind_q;
		n_phase    = phase_q;
		n_bit      = bit_q;
		n_shift    = shift_q;
		n_delay    = delay_q;
		n_ack_flag = ack_flag_q;
		n_scl      = scl_q;
		n_sda      = sda_q;
		n_rx       = rx_q;
		n_ack_hold = ack_hold_q;
		do_act     = 1'b0;
		fin        = 1'b0;
		if (kind_q == i2cbb_pkg::CMD_IDLE) begin
			if (q_item.kind != i2cbb_pkg::CMD_IDLE) begin
				n_kind  = q_item.kind;
				n_phase = 3'd0;
				n_bit   = 4'd0;
				n_delay = '0;
				if (q_item.kind == i2cbb_pkg::CMD_WRITE) begin
					n_shift = q_item.tx_byte;
				end else if (q_item.kind == i2cbb_pkg::CMD_READ) begin
					n_shift    = 8'd0;
					n_ack_hold = q_item.ack_to_send;
				end
				do_act = 1'b1;
			end
		end else if (delay_q != '0) begin
			n_delay = delay_q - i2cbb_pkg::DLY_W'(1);
			if (delay_q == i2cbb_pkg::DLY_W'(1) && phase_q == i2cbb_pkg::PH_END &&
			    (kind_q == i2cbb_pkg::CMD_START || kind_q == i2cbb_pkg::CMD_STOP)) begin
				fin = 1'b1;
			end
		end else begin
			do_act = 1'b1;
		end

		if (do_act) begin
			unique case (n_kind)
				i2cbb_pkg::CMD_START: begin
					case (n_phase)
						3'd0: begin n_sda = 1'b1; n_delay = dly_cfg_q; n_phase = 3'd1; end
						3'd1: begin n_scl = 1'b1; n_delay = dly_cfg_q; n_phase = 3'd2; end
						3'd2: begin n_sda = 1'b0; n_delay = dly_cfg_q; n_phase = 3'd3; end
						3'd3: begin
							n_scl = 1'b0;
							if (dly_cfg_q == '0) begin
								fin = 1'b1;
							end else begin
								n_delay = dly_cfg_q;
								n_phase = i2cbb_pkg::PH_END;
							end
						end
						default: fin = 1'b1;
					endcase
				end
				i2cbb_pkg::CMD_STOP: begin
					case (n_phase)
						3'd0: begin n_sda = 1'b0; n_delay = dly_cfg_q; n_phase = 3'd1; end
						3'd1: begin n_scl = 1'b1; n_delay = dly_cfg_q; n_phase = 3'd2; end
						3'd2: begin
							n_sda = 1'b1;
							if (dly_cfg_q == '0) begin
								fin = 1'b1;
							end else begin
								n_delay = dly_cfg_q;
								n_phase = i2cbb_pkg::PH_END;
							end
						end
						default: fin = 1'b1;
					endcase
				end
				i2cbb_pkg::CMD_WRITE: begin
					case (n_phase)
						3'd0: begin n_sda = n_shift[7]; n_phase = 3'd1; end
						3'd1: begin n_scl = 1'b1; n_phase = 3'd2; end
						3'd2: begin
							n_scl   = 1'b0;
							n_shift = {n_shift[6:0], 1'b0};
							n_bit   = n_bit + 4'd1;
							n_phase = n_bit[3] ? 3'd3 : 3'd0;
						end
						3'd3: begin n_sda = 1'b1; n_phase = 3'd4; end
						3'd4: begin n_scl = 1'b1; n_delay = dly_cfg_q; n_phase = 3'd5; end
						3'd5: begin n_ack_flag = q_item.sda_in; n_scl = 1'b0; fin = 1'b1; end
						default: fin = 1'b1;
					endcase
				end
				i2cbb_pkg::CMD_READ: begin
					case (n_phase)
						3'd0: begin n_sda = 1'b1; n_phase = 3'd1; end
						3'd1: begin n_scl = 1'b1; n_phase = 3'd2; end
						3'd2: begin
							if (q_item.scl_in) begin
								n_delay = dly_cfg_q;
								n_phase = 3'd3;
							end
						end
						3'd3: begin
							n_shift = {n_shift[6:0], q_item.sda_in};
							n_scl   = 1'b0;
							n_bit   = n_bit + 4'd1;
							n_phase = n_bit[3] ? 3'd4 : 3'd1;
						end
						3'd4: begin n_sda = !n_ack_hold; n_phase = 3'd5; end
						3'd5: begin n_scl = 1'b1; n_delay = dly_cfg_q; n_phase = 3'd6; end
						3'd6: begin n_scl = 1'b0; n_phase = 3'd7; end
						default: begin n_sda = 1'b1; n_rx = n_shift; fin = 1'b1; end
					endcase
				end
				default: fin = 1'b1;
			endcase
		end

		if (fin) begin
			n_kind  = i2cbb_pkg::CMD_IDLE;
			n_phase = 3'd0;
		end
	end

	always_comb begin
		done           = fin;
		n_res.scl_out  = n_scl;
		n_res.sda_out  = n_sda;
		n_res.busy_res = (n_kind != i2cbb_pkg::CMD_IDLE);
		n_res.done_res = done;
		n_res.rx_byte  = n_rx;
		n_res.ack_seen = n_ack_flag;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= n_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= i2cbb_pkg::CMD_IDLE;
			phase_q     <= 3'd0;
			bit_q       <= 4'd0;
			shift_q     <= 8'd0;
			delay_q     <= '0;
			dly_cfg_q   <= '0;
			ack_flag_q  <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			rx_q        <= 8'd0;
			ack_hold_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dly_cfg_q <= cfg_data;
			end
			if (q_pop) begin
				kind_q     <= n_kind;
				phase_q    <= n_phase;
				bit_q      <= n_bit;
				shift_q    <= n_shift;
				delay_q    <= n_delay;
				ack_flag_q <= n_ack_flag;
				scl_q      <= n_scl;
				sda_q      <= n_sda;
				rx_q       <= n_rx;
				ack_hold_q <= n_ack_hold;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= q_valid;
			end
		end
	end

endmodule

>>> hdl/i2c_bitbang_master_core.sv
// I2C bit-bang master, one bus phase per input beat.
// Input channel (in_valid / in_stall): each beat is one tick carrying a command
// code (op), the byte to send, the ACK choice of a read and the sampled SDA and
// SCL pin levels. Commands are taken only while no command runs; other beats
// advance it a phase, count down a delay, or wait for SCL high in a read.
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat, in order: SCL/SDA drives, busy, done pulse, last read byte, last ACK.
// Configuration channel (cfg_valid / cfg_ready, always ready): writes the
// 16-bit phase delay, applied from the next delay point.
// A result passes through the command queue and then the engine's output
// register before it appears.
// Throughput: one beat per cycle; the engine updates its state on each beat.
// When the receiver stalls, the result is held, the engine pauses and the
// queue of QUEUE_DEPTH beats fills before in_stall rises.
// Reset: drive state released high, no command running, delay 0, read byte and
// ACK flag 0, queue empty; the result register (outputs) is not reset.
module i2c_bitbang_master_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   op,
	input  logic [7:0]                   tx_byte,
	input  logic                         ack_to_send,
	input  logic                         sda_in,
	input  logic                         scl_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         scl_out,
	output logic                         sda_out,
	output logic                         busy_res,
	output logic                         done_res,
	output logic [7:0]                   rx_byte,
	output logic                         ack_seen,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [i2cbb_pkg::DLY_W-1:0]  cfg_data
);

	logic              q_valid;
	logic              q_pop;
	i2cbb_pkg::item_t  q_item;
	i2cbb_pkg::res_t   res;

	i2cbb_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.tx_byte     (tx_byte),
		.ack_to_send (ack_to_send),
		.sda_in      (sda_in),
		.scl_in      (scl_in),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	i2cbb_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign scl_out  = res.scl_out;
	assign sda_out  = res.sda_out;
	assign busy_res = res.busy_res;
	assign done_res = res.done_res;
	assign rx_byte  = res.rx_byte;
	assign ack_seen = res.ack_seen;

endmodule

>>> hdl/i2cbb_checker.sv
module i2cbb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         scl_out,
	input logic                         sda_out,
	input logic                         busy_res,
	input logic                         done_res,
	input logic [7:0]                   rx_byte,
	input logic                         ack_seen,
	input logic                         cfg_valid,
	input logic                         cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scl_out) && $stable(sda_out) &&
			$stable(busy_res) && $stable(done_res) && $stable(rx_byte) && $stable(ack_seen))
		else $error("stalled result beat changed");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done beat still reports busy");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("result or stall present right after reset");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind i2c_bitbang_master_core i2cbb_checker u_chk (.*);

>>> test/tb_i2c_bitbang_master_core.sv
`timescale 1ns / 100ps

module tb_i2c_bitbang_master_core;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam logic [2:0] OP_NOP = 3'd0;
	localparam logic [2:0] SPARE_OPS [3] = '{3'd5, 3'd6, 3'd7};
	localparam i2cbb_pkg::res_t RES_IDLE = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
		done_res: 1'b0, rx_byte: 8'h00, ack_seen: 1'b0};

	typedef struct packed {
		logic [2:0]      op;
		logic [7:0]      tx;
		logic            ack;
		logic            sda;
		logic            scl;
		logic            typed;
		i2cbb_pkg::res_t want;
	} dir_row_t;

	typedef struct {
		logic [15:0] dly;
		int          mode;
		int unsigned n;
		logic [2:0]  lead;
	} seg_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] op;
	logic [7:0] tx_byte;
	logic ack_to_send;
	logic sda_in;
	logic scl_in;
	logic out_valid;
	logic out_stall;
	logic scl_out;
	logic sda_out;
	logic busy_res;
	logic done_res;
	logic [7:0] rx_byte;
	logic ack_seen;
	logic cfg_valid;
	logic cfg_ready;
	logic [i2cbb_pkg::DLY_W-1:0] cfg_data;

	logic [15:0]     dly_cfg;
	i2cbb_pkg::cmd_t eng_kind;
	logic [2:0]      eng_phase;
	logic [3:0]      eng_bits;
	logic [7:0]      eng_shift;
	logic [7:0]      eng_rx;
	logic [15:0]     eng_wait;
	logic            eng_ack;
	logic            eng_scl;
	logic            eng_sda;
	logic            eng_ack_choice;

	i2cbb_pkg::res_t bus_state_q [$];
	dir_row_t        dir_rows [0:15];
	seg_t            segs [0:5];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned work_beats;
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;

	i2c_bitbang_master_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.tx_byte(tx_byte),
		.ack_to_send(ack_to_send),
		.sda_in(sda_in),
		.scl_in(scl_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.scl_out(scl_out),
		.sda_out(sda_out),
		.busy_res(busy_res),
		.done_res(done_res),
		.rx_byte(rx_byte),
		.ack_seen(ack_seen),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit eng_finish();
		eng_kind = i2cbb_pkg::CMD_IDLE;
		eng_phase = 3'd0;
		return 1'b1;
	endfunction

	function automatic bit eng_last_change();
		if (dly_cfg == 16'd0)
			return eng_finish();
		eng_wait = dly_cfg;
		eng_phase = i2cbb_pkg::PH_END;
		return 1'b0;
	endfunction

	function automatic bit eng_advance(input logic sda_pin, input logic scl_pin);
		bit done;
		done = 1'b0;
		case (eng_kind)
		i2cbb_pkg::CMD_START: begin
			case (eng_phase)
			3'd0: begin eng_sda = 1'b1; eng_wait = dly_cfg; eng_phase = 3'd1; end
			3'd1: begin eng_scl = 1'b1; eng_wait = dly_cfg; eng_phase = 3'd2; end
			3'd2: begin eng_sda = 1'b0; eng_wait = dly_cfg; eng_phase = 3'd3; end
			3'd3: begin eng_scl = 1'b0; done = eng_last_change(); end
			default: done = eng_finish();
			endcase
		end
		i2cbb_pkg::CMD_STOP: begin
			case (eng_phase)
			3'd0: begin eng_sda = 1'b0; eng_wait = dly_cfg; eng_phase = 3'd1; end
			3'd1: begin eng_scl = 1'b1; eng_wait = dly_cfg; eng_phase = 3'd2; end
			3'd2: begin eng_sda = 1'b1; done = eng_last_change(); end
			default: done = eng_finish();
			endcase
		end
		i2cbb_pkg::CMD_WRITE: begin
			case (eng_phase)
			3'd0: begin eng_sda = eng_shift[7]; eng_phase = 3'd1; end
			3'd1: begin eng_scl = 1'b1; eng_phase = 3'd2; end
			3'd2: begin
				eng_scl = 1'b0;
				eng_shift = {eng_shift[6:0], 1'b0};
				eng_bits = eng_bits + 4'd1;
				eng_phase = (eng_bits >= 4'd8) ? 3'd3 : 3'd0;
			end
			3'd3: begin eng_sda = 1'b1; eng_phase = 3'd4; end
			3'd4: begin eng_scl = 1'b1; eng_wait = dly_cfg; eng_phase = 3'd5; end
			3'd5: begin eng_ack = sda_pin; eng_scl = 1'b0; done = eng_finish(); end
			default: done = eng_finish();
			endcase
		end
		i2cbb_pkg::CMD_READ: begin
			case (eng_phase)
			3'd0: begin eng_sda = 1'b1; eng_phase = 3'd1; end
			3'd1: begin eng_scl = 1'b1; eng_phase = 3'd2; end
			3'd2: begin
				if (scl_pin) begin
					eng_wait = dly_cfg;
					eng_phase = 3'd3;
				end
			end
			3'd3: begin
				eng_shift = {eng_shift[6:0], sda_pin};
				eng_scl = 1'b0;
				eng_bits = eng_bits + 4'd1;
				eng_phase = (eng_bits >= 4'd8) ? 3'd4 : 3'd1;
			end
			3'd4: begin eng_sda = ~eng_ack_choice; eng_phase = 3'd5; end
			3'd5: begin eng_scl = 1'b1; eng_wait = dly_cfg; eng_phase = 3'd6; end
			3'd6: begin eng_scl = 1'b0; eng_phase = 3'd7; end
			default: begin eng_sda = 1'b1; eng_rx = eng_shift; done = eng_finish(); end
			endcase
		end
		default: done = eng_finish();
		endcase
		return done;
	endfunction

	function automatic i2cbb_pkg::res_t bus_tick(input logic [2:0] op_v,
		input logic [7:0] tx_v, input logic ack_v, input logic sda_v, input logic scl_v);
		bit done;
		done = 1'b0;
		if (eng_kind == i2cbb_pkg::CMD_IDLE) begin
			if (op_v >= i2cbb_pkg::OP_START && op_v <= i2cbb_pkg::OP_READ) begin
				eng_kind = i2cbb_pkg::cmd_t'(op_v);
				eng_phase = 3'd0;
				eng_bits = 4'd0;
				eng_wait = 16'd0;
				if (op_v == i2cbb_pkg::OP_WRITE) begin
					eng_shift = tx_v;
				end else if (op_v == i2cbb_pkg::OP_READ) begin
					eng_shift = 8'h00;
					eng_ack_choice = ack_v;
				end
				done = eng_advance(sda_v, scl_v);
			end
		end else if (eng_wait != 16'd0) begin
			eng_wait = eng_wait - 16'd1;
			if (eng_wait == 16'd0 && eng_phase == i2cbb_pkg::PH_END &&
				(eng_kind == i2cbb_pkg::CMD_START || eng_kind == i2cbb_pkg::CMD_STOP))
				done = eng_finish();
		end else begin
			done = eng_advance(sda_v, scl_v);
		end
		return '{scl_out: eng_scl, sda_out: eng_sda,
			busy_res: eng_kind != i2cbb_pkg::CMD_IDLE,
			done_res: done, rx_byte: eng_rx, ack_seen: eng_ack};
	endfunction

	function automatic void check_field(input string fname, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
		end
	endfunction

	task automatic send_beat(input logic [2:0] op_v, input logic [7:0] tx_v,
		input logic ack_v, input logic sda_v, input logic scl_v,
		input logic typed, input i2cbb_pkg::res_t typed_res);
		i2cbb_pkg::res_t r;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op = op_v;
		tx_byte = tx_v;
		ack_to_send = ack_v;
		sda_in = sda_v;
		scl_in = scl_v;
		do @(posedge clk); while (in_stall);
		if (eng_kind != i2cbb_pkg::CMD_IDLE ||
			(op_v >= i2cbb_pkg::OP_START && op_v <= i2cbb_pkg::OP_READ))
			work_beats++;
		r = bus_tick(op_v, tx_v, ack_v, sda_v, scl_v);
		bus_state_q.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		i2cbb_pkg::res_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else if (arst_n && out_valid && !out_stall) begin
			if (bus_state_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected", $time);
			end else begin
				want = bus_state_q.pop_front();
				check_field("scl_out", want.scl_out, scl_out);
				check_field("sda_out", want.sda_out, sda_out);
				check_field("busy_res", want.busy_res, busy_res);
				check_field("done_res", want.done_res, done_res);
				check_field("rx_byte", want.rx_byte, rx_byte);
				check_field("ack_seen", want.ack_seen, ack_seen);
			end
		end
	end

	initial begin
		int s;
		int seq_step;
		int stretch_left;
		int unsigned pick;
		logic [2:0] op_v;
		logic [7:0] tx_v;
		logic ack_v;
		logic sda_v;
		logic scl_v;

		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_NOP;
		tx_byte = 8'h00;
		ack_to_send = 1'b0;
		sda_in = 1'b1;
		scl_in = 1'b1;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;

		dly_cfg = 16'd0;
		eng_kind = i2cbb_pkg::CMD_IDLE;
		eng_phase = 3'd0;
		eng_bits = 4'd0;
		eng_shift = 8'h00;
		eng_rx = 8'h00;
		eng_wait = 16'd0;
		eng_ack = 1'b0;
		eng_scl = 1'b1;
		eng_sda = 1'b1;
		eng_ack_choice = 1'b0;
		seq_step = 0;
		stretch_left = 0;

		dir_rows = '{
			'{OP_NOP,              8'h00, 1'b0, 1'b0, 1'b0, 1'b1, RES_IDLE},
			'{SPARE_OPS[0],        8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, RES_IDLE},
			'{SPARE_OPS[1],        8'h00, 1'b0, 1'b1, 1'b0, 1'b1, RES_IDLE},
			'{SPARE_OPS[2],        8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, RES_IDLE},
			'{i2cbb_pkg::OP_START, 8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, RES_IDLE},
			'{i2cbb_pkg::OP_STOP,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, RES_IDLE},
			'{i2cbb_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, RES_IDLE},
			'{i2cbb_pkg::OP_READ,  8'h00, 1'b1, 1'b1, 1'b1, 1'b0, RES_IDLE},
			'{i2cbb_pkg::OP_STOP,  8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, RES_IDLE},
			'{i2cbb_pkg::OP_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, RES_IDLE},
			'{i2cbb_pkg::OP_READ,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, RES_IDLE},
			'{i2cbb_pkg::OP_READ,  8'h00, 1'b1, 1'b1, 1'b1, 1'b0, RES_IDLE},
			'{i2cbb_pkg::OP_WRITE, 8'hA5, 1'b0, 1'b1, 1'b1, 1'b0, RES_IDLE},
			'{OP_NOP,              8'h00, 1'b0, 1'b1, 1'b0, 1'b0, RES_IDLE},
			'{OP_NOP,              8'h00, 1'b0, 1'b1, 1'b0, 1'b0, RES_IDLE},
			'{OP_NOP,              8'h00, 1'b0, 1'b1, 1'b0, 1'b0, RES_IDLE}
		};

		segs[0] = '{16'd0, 0, 300, OP_NOP};
		segs[1] = '{16'd3, 0, 200, OP_NOP};
		segs[2] = '{16'd1, 1, 250, OP_NOP};
		segs[3] = '{16'($urandom_range(2, 12)), 1, 200, OP_NOP};
		segs[4] = '{16'd0, 2, 300, OP_NOP};
		segs[5] = '{16'd64, 2, 1, i2cbb_pkg::OP_WRITE};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (s = 0; s < 6; s++) begin
			while (bus_state_q.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			@(negedge clk);
			cfg_valid = 1'b1;
			cfg_data = segs[s].dly;
			do @(posedge clk); while (!cfg_ready);
			dly_cfg = segs[s].dly;
			@(negedge clk);
			cfg_valid = 1'b0;

			case (segs[s].mode)
			0: begin gap_pct = 20; stall_pct = 72; end
			1: begin gap_pct = 72; stall_pct = 20; end
			default: begin gap_pct = 0; stall_pct = 0; end
			endcase

			if (s == 0) begin
				foreach (dir_rows[i])
					send_beat(dir_rows[i].op, dir_rows[i].tx, dir_rows[i].ack,
						dir_rows[i].sda, dir_rows[i].scl, dir_rows[i].typed,
						dir_rows[i].want);
			end

			work_beats = 0;
			while (work_beats < segs[s].n || eng_kind != i2cbb_pkg::CMD_IDLE) begin
				if (eng_kind == i2cbb_pkg::CMD_IDLE) begin
					if (segs[s].lead != OP_NOP) begin
						op_v = segs[s].lead;
					end else if ($urandom_range(0, 19) == 0) begin
						pick = $urandom_range(0, 3);
						op_v = (pick == 0) ? OP_NOP : SPARE_OPS[pick - 1];
					end else if ($urandom_range(0, 9) == 0) begin
						op_v = 3'($urandom_range(i2cbb_pkg::OP_START, i2cbb_pkg::OP_READ));
					end else begin
						case (seq_step)
						0: begin op_v = i2cbb_pkg::OP_START; seq_step = 1; end
						1: begin op_v = i2cbb_pkg::OP_WRITE; seq_step = 2; end
						default: begin
							pick = $urandom_range(0, 3);
							op_v = (pick == 0) ? i2cbb_pkg::OP_STOP :
								(pick == 1) ? i2cbb_pkg::OP_WRITE : i2cbb_pkg::OP_READ;
							if (pick == 0)
								seq_step = 0;
						end
						endcase
					end
				end else begin
					op_v = 3'($urandom_range(0, 7));
				end
				pick = $urandom_range(0, 7);
				tx_v = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
				ack_v = 1'($urandom_range(0, 1));
				sda_v = 1'($urandom_range(0, 1));
				if (stretch_left > 0) begin
					scl_v = 1'b0;
					stretch_left--;
				end else if ($urandom_range(0, 149) == 0) begin
					scl_v = 1'b0;
					stretch_left = $urandom_range(10, 40);
				end else begin
					scl_v = ($urandom_range(0, 99) < 75);
				end
				send_beat(op_v, tx_v, ack_v, sda_v, scl_v, 1'b0, RES_IDLE);
			end
			in_valid = 1'b0;
		end

		while (bus_state_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
hdl/i2cbb_pkg.sv
hdl/i2cbb_front.sv
hdl/i2cbb_engine.sv
hdl/i2c_bitbang_master_core.sv
hdl/i2cbb_checker.sv
test/tb_i2c_bitbang_master_core.sv
